// ===== src/vector3_arithmetic_unit_macros.svh =====
// assertion helpers used by the top-level rtl
`ifndef VECTOR3_ARITHMETIC_UNIT_MACROS_SVH
`define VECTOR3_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define VAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/vau_pkg.sv =====
`default_nettype none

package vau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W = 2 * WORD_BITS;
	localparam int SAT_W = 2 * WORD_BITS + 4;
	localparam int RAD_W = 2 * WORD_BITS;
	localparam int NUM_W = WORD_BITS + FRAC_BITS;
	localparam int LANES = 3;

	localparam logic signed [SAT_W-1:0] RND_HALF =
		{{(SAT_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		FN_ADD   = 3'd0,
		FN_SUB   = 3'd1,
		FN_NEG   = 3'd2,
		FN_SCALE = 3'd3,
		FN_DOT   = 3'd4,
		FN_CROSS = 3'd5,
		FN_LEN   = 3'd6,
		FN_NORM  = 3'd7
	} func_t;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [2:0] func;
		word_t      a_x;
		word_t      a_y;
		word_t      a_z;
		word_t      b_x;
		word_t      b_y;
		word_t      b_z;
		word_t      scale_factor;
	} in_item_t;

	typedef struct packed {
		word_t res_x;
		word_t res_y;
		word_t res_z;
		word_t res_scalar;
		logic  zero_length;
		logic  overflow;
	} out_item_t;

	typedef struct packed {
		word_t val;
		logic  ovf;
	} sat_t;

	// carried alongside the square root
	typedef struct packed {
		func_t                              func;
		logic [LANES-1:0]                   neg;
		logic [LANES-1:0][WORD_BITS-1:0]    mag;
		out_item_t                          res;
	} root_side_t;

	// carried alongside the dividers
	typedef struct packed {
		func_t                 func;
		logic [LANES-1:0]      neg;
		logic [WORD_BITS-1:0]  len;
		out_item_t             res;
	} div_side_t;

	// clamp to the word range, flag when clamped
	function automatic sat_t saturate(input logic signed [SAT_W-1:0] v);
		sat_t r;
		logic [SAT_W-WORD_BITS:0] top;
		top = v[SAT_W-1:WORD_BITS-1];
		r.ovf = !((&top) || !(|top));
		if (r.ovf) begin
			r.val = v[SAT_W-1] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
		end else begin
			r.val = v[WORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/vau_root.sv =====
`default_nettype none

module vau_root #(
	parameter int RAD_BITS = 64,
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [RAD_BITS-1:0]   rad,
	input  logic [SIDE_W-1:0]     side_in,
	output logic                  out_vld,
	output logic [RAD_BITS/2-1:0] root,
	output logic [SIDE_W-1:0]     side_out
);

	localparam int ROOT_W = RAD_BITS / 2;
	localparam int STEPS = ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int SH_W = REM_W + 2;

	logic                vld_s  [STEPS];
	logic [REM_W-1:0]    rem_s  [STEPS];
	logic [ROOT_W-1:0]   root_s [STEPS];
	logic [RAD_BITS-1:0] rad_s  [STEPS];
	logic [SIDE_W-1:0]   side_s [STEPS];

	// one result bit per stage, restoring method
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic                vld_p;
		logic [REM_W-1:0]    rem_p;
		logic [ROOT_W-1:0]   root_p;
		logic [RAD_BITS-1:0] rad_p;
		logic [SIDE_W-1:0]   side_p;
		logic [SH_W-1:0]     sh;
		logic [SH_W-1:0]     trial;
		logic                ge;

		if (k == 0) begin : g_head
			assign vld_p = in_vld;
			assign rem_p = '0;
			assign root_p = '0;
			assign rad_p = rad;
			assign side_p = side_in;
		end else begin : g_tail
			assign vld_p = vld_s[k-1];
			assign rem_p = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p = rad_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign sh = {rem_p, rad_p[RAD_BITS-1 -: 2]};
		assign trial = SH_W'({root_p, 2'b01});
		assign ge = (sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? REM_W'(sh - trial) : REM_W'(sh);
				root_s[k] <= {root_p[ROOT_W-2:0], ge};
				rad_s[k] <= {rad_p[RAD_BITS-3:0], 2'b00};
				side_s[k] <= side_p;
			end
		end
	end

	assign out_vld = vld_s[STEPS-1];
	assign root = root_s[STEPS-1];
	assign side_out = side_s[STEPS-1];

endmodule

`default_nettype wire

// ===== src/vau_div.sv =====
`default_nettype none

module vau_div #(
	parameter int NUM_BITS = 48,
	parameter int DEN_BITS = 32,
	parameter int NLANES = 3,
	parameter int SIDE_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  logic [NLANES-1:0][NUM_BITS-1:0]  num,
	input  logic [DEN_BITS-1:0]              den,
	input  logic [SIDE_W-1:0]                side_in,
	output logic                             out_vld,
	output logic [NLANES-1:0][NUM_BITS-1:0]  quo,
	output logic [SIDE_W-1:0]                side_out
);

	localparam int STEPS = NUM_BITS;

	logic                            vld_s  [STEPS];
	logic [NLANES-1:0][DEN_BITS-1:0] rem_s  [STEPS];
	logic [NLANES-1:0][NUM_BITS-1:0] qn_s   [STEPS];
	logic [DEN_BITS-1:0]             den_s  [STEPS];
	logic [SIDE_W-1:0]               side_s [STEPS];

	// one quotient bit per stage; dividend bits leave the top as quotient bits enter
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic                            vld_p;
		logic [NLANES-1:0][DEN_BITS-1:0] rem_p;
		logic [NLANES-1:0][NUM_BITS-1:0] qn_p;
		logic [DEN_BITS-1:0]             den_p;
		logic [SIDE_W-1:0]               side_p;
		logic [NLANES-1:0][DEN_BITS-1:0] rem_n;
		logic [NLANES-1:0][NUM_BITS-1:0] qn_n;

		if (k == 0) begin : g_head
			assign vld_p = in_vld;
			assign rem_p = '0;
			assign qn_p = num;
			assign den_p = den;
			assign side_p = side_in;
		end else begin : g_tail
			assign vld_p = vld_s[k-1];
			assign rem_p = rem_s[k-1];
			assign qn_p = qn_s[k-1];
			assign den_p = den_s[k-1];
			assign side_p = side_s[k-1];
		end

		for (genvar l = 0; l < NLANES; l++) begin : g_lane
			logic [DEN_BITS:0] sh;
			logic              ge;
			assign sh = {rem_p[l], qn_p[l][NUM_BITS-1]};
			assign ge = (sh >= {1'b0, den_p});
			assign rem_n[l] = ge ? DEN_BITS'(sh - {1'b0, den_p}) : sh[DEN_BITS-1:0];
			assign qn_n[l] = {qn_p[l][NUM_BITS-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_n;
				qn_s[k] <= qn_n;
				den_s[k] <= den_p;
				side_s[k] <= side_p;
			end
		end
	end

	assign out_vld = vld_s[STEPS-1];
	assign quo = qn_s[STEPS-1];
	assign side_out = side_s[STEPS-1];

endmodule

`default_nettype wire

// ===== src/vector3_arithmetic_unit.sv =====
// every operation runs through every stage, root and dividers too, before it shows on rsp
// throughput: one item per cycle while the skid register is empty; all operations share one
//   in-order pipeline, depth set by the root (32 stages) and normalize dividers (48 stages)
// a waiting result parks in a skid register, so one more item is taken before the input stalls
// reset (arst_n low) empties every stage and the output; no item is lost or invented afterward
`default_nettype none
`include "vector3_arithmetic_unit_macros.svh"

module vector3_arithmetic_unit import vau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	localparam int ROOT_SIDE_W = $bits(root_side_t);
	localparam int DIV_SIDE_W = $bits(div_side_t);

	// whole pipeline moves together; it halts only while the skid register is full
	logic en;

	// ---------------------------------------------------------------- stage 1: products
	word_t av [LANES];
	word_t ar1 [LANES];
	word_t ar2 [LANES];
	word_t bv [LANES];
	word_t br1 [LANES];
	word_t br2 [LANES];
	word_t ml [2*LANES];
	word_t mr [2*LANES];
	logic signed [WORD_BITS:0] as_c [LANES];
	logic [WORD_BITS-1:0] mag_c [LANES];

	logic v_s1;
	func_t func_s1;
	logic signed [PROD_W-1:0] prod_s1 [2*LANES];
	logic signed [WORD_BITS:0] as_s1 [LANES];
	logic [LANES-1:0][WORD_BITS-1:0] mag_s1;
	logic [LANES-1:0] neg_s1;

	always_comb begin
		av = '{req.a_x, req.a_y, req.a_z};
		ar1 = '{req.a_y, req.a_z, req.a_x};
		ar2 = '{req.a_z, req.a_x, req.a_y};
		bv = '{req.b_x, req.b_y, req.b_z};
		br1 = '{req.b_y, req.b_z, req.b_x};
		br2 = '{req.b_z, req.b_x, req.b_y};
		for (int i = 0; i < LANES; i++) begin
			// upper three multipliers only matter for the cross product
			ml[i+LANES] = ar2[i];
			mr[i+LANES] = br1[i];
			unique case (func_t'(req.func))
				FN_SCALE: begin
					ml[i] = av[i];
					mr[i] = req.scale_factor;
				end
				FN_DOT: begin
					ml[i] = av[i];
					mr[i] = bv[i];
				end
				FN_CROSS: begin
					ml[i] = ar1[i];
					mr[i] = br2[i];
				end
				FN_ADD, FN_SUB, FN_NEG, FN_LEN, FN_NORM: begin
					// squares for length and normalize
					ml[i] = av[i];
					mr[i] = av[i];
				end
			endcase
			unique case (func_t'(req.func))
				FN_ADD: as_c[i] = {av[i][WORD_BITS-1], av[i]} + {bv[i][WORD_BITS-1], bv[i]};
				FN_SUB: as_c[i] = {av[i][WORD_BITS-1], av[i]} - {bv[i][WORD_BITS-1], bv[i]};
				FN_NEG: as_c[i] = -{av[i][WORD_BITS-1], av[i]};
				FN_SCALE, FN_DOT, FN_CROSS, FN_LEN, FN_NORM: as_c[i] = '0;
			endcase
			mag_c[i] = av[i][WORD_BITS-1] ? WORD_BITS'(-av[i]) : WORD_BITS'(av[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func_t'(req.func);
			for (int i = 0; i < 2*LANES; i++) begin
				prod_s1[i] <= ml[i] * mr[i];
			end
			for (int i = 0; i < LANES; i++) begin
				as_s1[i] <= as_c[i];
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= av[i][WORD_BITS-1];
			end
		end
	end

	// ---------------------------------------------------------------- stage 2: combine terms
	logic v_s2;
	func_t func_s2;
	logic signed [SAT_W-1:0] vec_s2 [LANES];
	logic signed [SAT_W-1:0] pair_s2;
	logic signed [PROD_W-1:0] p2_s2;
	sat_t as_sat_s2 [LANES];
	logic [LANES-1:0][WORD_BITS-1:0] mag_s2;
	logic [LANES-1:0] neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			for (int i = 0; i < LANES; i++) begin
				// cross subtracts the paired term, scale keeps the plain product
				vec_s2[i] <= (func_s1 == FN_CROSS) ?
					SAT_W'(prod_s1[i]) - SAT_W'(prod_s1[i+LANES]) : SAT_W'(prod_s1[i]);
				as_sat_s2[i] <= saturate(SAT_W'(as_s1[i]));
			end
			pair_s2 <= SAT_W'(prod_s1[0]) + SAT_W'(prod_s1[1]);
			p2_s2 <= prod_s1[2];
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3: round, sum
	logic v_s3;
	func_t func_s3;
	logic signed [SAT_W-1:0] vr_s3 [LANES];
	logic signed [SAT_W-1:0] sum_s3;
	sat_t as_sat_s3 [LANES];
	logic [LANES-1:0][WORD_BITS-1:0] mag_s3;
	logic [LANES-1:0] neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s3 <= func_s2;
			for (int i = 0; i < LANES; i++) begin
				// round half up, then drop the fraction
				vr_s3[i] <= (vec_s2[i] + RND_HALF) >>> FRAC_BITS;
			end
			sum_s3 <= pair_s2 + SAT_W'(p2_s2);
			as_sat_s3 <= as_sat_s2;
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4: saturate vectors
	logic v_s4;
	func_t func_s4;
	sat_t vsat_s4 [LANES];
	logic signed [SAT_W-1:0] dr_s4;
	logic [RAD_W-1:0] rad_s4;
	sat_t as_sat_s4 [LANES];
	logic [LANES-1:0][WORD_BITS-1:0] mag_s4;
	logic [LANES-1:0] neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s4 <= func_s3;
			for (int i = 0; i < LANES; i++) begin
				vsat_s4[i] <= saturate(vr_s3[i]);
			end
			dr_s4 <= (sum_s3 + RND_HALF) >>> FRAC_BITS;
			// sum of squares is never negative and fits the radicand
			rad_s4 <= sum_s3[RAD_W-1:0];
			as_sat_s4 <= as_sat_s3;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
		end
	end

	// ---------------------------------------------------------------- stage 5: pick result
	sat_t dsat_c;
	out_item_t res_c;

	logic v_s5;
	root_side_t rside_s5;
	logic [RAD_W-1:0] rad_s5;

	always_comb begin
		dsat_c = saturate(dr_s4);
		res_c = '0;
		unique case (func_s4)
			FN_ADD, FN_SUB, FN_NEG: begin
				res_c.res_x = as_sat_s4[0].val;
				res_c.res_y = as_sat_s4[1].val;
				res_c.res_z = as_sat_s4[2].val;
				res_c.overflow = as_sat_s4[0].ovf | as_sat_s4[1].ovf | as_sat_s4[2].ovf;
			end
			FN_SCALE, FN_CROSS: begin
				res_c.res_x = vsat_s4[0].val;
				res_c.res_y = vsat_s4[1].val;
				res_c.res_z = vsat_s4[2].val;
				res_c.overflow = vsat_s4[0].ovf | vsat_s4[1].ovf | vsat_s4[2].ovf;
			end
			FN_DOT: begin
				res_c.res_scalar = dsat_c.val;
				res_c.overflow = dsat_c.ovf;
			end
			FN_LEN, FN_NORM: begin
				// filled in after the root and dividers
				res_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rside_s5.func <= func_s4;
			rside_s5.neg <= neg_s4;
			rside_s5.mag <= mag_s4;
			rside_s5.res <= res_c;
			rad_s5 <= rad_s4;
		end
	end

	// ---------------------------------------------------------------- square root
	logic root_vld;
	logic [WORD_BITS-1:0] root_len;
	root_side_t rside_out;

	vau_root #(
		.RAD_BITS (RAD_W),
		.SIDE_W   (ROOT_SIDE_W)
	) u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s5),
		.rad      (rad_s5),
		.side_in  (rside_s5),
		.out_vld  (root_vld),
		.root     (root_len),
		.side_out (rside_out)
	);

	// ---------------------------------------------------------------- normalize dividers
	logic [LANES-1:0][NUM_W-1:0] div_num;
	div_side_t dside_in;
	logic div_vld;
	logic [LANES-1:0][NUM_W-1:0] div_quo;
	div_side_t dside_out;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			div_num[i] = {rside_out.mag[i], {FRAC_BITS{1'b0}}};
		end
		dside_in.func = rside_out.func;
		dside_in.neg = rside_out.neg;
		dside_in.len = root_len;
		dside_in.res = rside_out.res;
	end

	vau_div #(
		.NUM_BITS (NUM_W),
		.DEN_BITS (WORD_BITS),
		.NLANES   (LANES),
		.SIDE_W   (DIV_SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (root_vld),
		.num      (div_num),
		.den      (root_len),
		.side_in  (dside_in),
		.out_vld  (div_vld),
		.quo      (div_quo),
		.side_out (dside_out)
	);

	// ---------------------------------------------------------------- stage 6: length, normalize
	out_item_t fin_c;
	sat_t lsat_c;
	sat_t nsat_c [LANES];
	logic signed [SAT_W-1:0] qe_c [LANES];

	logic v_s6;
	out_item_t fin_s6;

	always_comb begin
		fin_c = dside_out.res;
		lsat_c = saturate($signed(SAT_W'(dside_out.len)));
		for (int i = 0; i < LANES; i++) begin
			qe_c[i] = $signed(SAT_W'(div_quo[i]));
			nsat_c[i] = saturate(dside_out.neg[i] ? -qe_c[i] : qe_c[i]);
		end
		if (dside_out.func == FN_LEN) begin
			fin_c.res_scalar = lsat_c.val;
			fin_c.overflow = lsat_c.ovf;
		end else if (dside_out.func == FN_NORM) begin
			if (dside_out.len == '0) begin
				// zero vector: zero result and the flag
				fin_c.zero_length = 1'b1;
			end else begin
				fin_c.res_x = nsat_c[0].val;
				fin_c.res_y = nsat_c[1].val;
				fin_c.res_z = nsat_c[2].val;
				fin_c.overflow = nsat_c[0].ovf | nsat_c[1].ovf | nsat_c[2].ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s6 <= fin_c;
		end
	end

	// ---------------------------------------------------------------- output and skid
	logic out_vld_q;
	logic skid_vld_q;
	out_item_t out_q;
	out_item_t skid_q;
	logic arrive;

	assign en = !skid_vld_q;
	assign req_ready = en;
	assign arrive = en && v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (arrive) begin
			if (!out_vld_q || rsp_ready) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (rsp_ready) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (arrive && (!out_vld_q || rsp_ready)) begin
			out_q <= fin_s6;
		end else if (skid_vld_q && rsp_ready) begin
			out_q <= skid_q;
		end
		if (arrive && out_vld_q && !rsp_ready) begin
			skid_q <= fin_s6;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp = out_q;

	// ---------------------------------------------------------------- checks
	`VAU_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_vld_q, out_vld_q, "skid holds an item with no output item")
	`VAU_ASSERT_NEXT(a_stall_parks, clk, arst_n, arrive && out_vld_q && !rsp_ready, skid_vld_q && out_vld_q, "finished item not parked in skid")
	`VAU_ASSERT_NOW(a_zero_len_clean, clk, arst_n, out_vld_q && out_q.zero_length, (out_q.res_x == '0) && (out_q.res_y == '0) && (out_q.res_z == '0) && (out_q.res_scalar == '0) && !out_q.overflow, "zero length with nonzero result")
	`VAU_ASSERT_NOW(a_scalar_or_vector, clk, arst_n, out_vld_q && (out_q.res_scalar != '0), (out_q.res_x == '0) && (out_q.res_y == '0) && (out_q.res_z == '0), "scalar and vector result both set")

endmodule

`default_nettype wire

// ===== dv/vector3_arithmetic_unit_checker.sv =====
`timescale 1ns / 1ps

module vector3_arithmetic_unit_checker import vau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  in_item_t  req,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  out_item_t rsp,
	output int        fail_count,
	output int        pending,
	output int        results_seen
);

	out_item_t expected_q[$];

	// clamp a wide signed value to one word
	function automatic word_t clamp_word(input logic signed [127:0] v, inout logic ovf);
		if (v > 128'sd2147483647) begin
			ovf = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			ovf = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
		return (v + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic logic [63:0] floor_root(input logic [127:0] s);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= s) r = c;
		end
		return r;
	endfunction

	function automatic out_item_t vector_result(input in_item_t it);
		out_item_t o;
		logic ovf;
		logic signed [127:0] a[3], b[3], s, acc;
		logic [127:0] sq, num, q;
		logic [63:0] len;
		ovf = 1'b0;
		o = '0;
		a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
		b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
		s = it.scale_factor;
		case (func_t'(it.func))
			FN_ADD: begin
				o.res_x = clamp_word(a[0] + b[0], ovf);
				o.res_y = clamp_word(a[1] + b[1], ovf);
				o.res_z = clamp_word(a[2] + b[2], ovf);
			end
			FN_SUB: begin
				o.res_x = clamp_word(a[0] - b[0], ovf);
				o.res_y = clamp_word(a[1] - b[1], ovf);
				o.res_z = clamp_word(a[2] - b[2], ovf);
			end
			FN_NEG: begin
				o.res_x = clamp_word(-a[0], ovf);
				o.res_y = clamp_word(-a[1], ovf);
				o.res_z = clamp_word(-a[2], ovf);
			end
			FN_SCALE: begin
				o.res_x = clamp_word(round_q(a[0] * s), ovf);
				o.res_y = clamp_word(round_q(a[1] * s), ovf);
				o.res_z = clamp_word(round_q(a[2] * s), ovf);
			end
			FN_DOT: begin
				acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
				o.res_scalar = clamp_word(round_q(acc), ovf);
			end
			FN_CROSS: begin
				o.res_x = clamp_word(round_q(a[1] * b[2] - a[2] * b[1]), ovf);
				o.res_y = clamp_word(round_q(a[2] * b[0] - a[0] * b[2]), ovf);
				o.res_z = clamp_word(round_q(a[0] * b[1] - a[1] * b[0]), ovf);
			end
			default: begin
				sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
				len = floor_root(sq);
				if (func_t'(it.func) == FN_LEN) begin
					o.res_scalar = clamp_word($signed({64'd0, len}), ovf);
				end else if (len == 0) begin
					o.zero_length = 1'b1;
				end else begin
					// divide the magnitude, then restore the sign
					num = (a[0] < 0 ? -a[0] : a[0]) << FRAC_BITS;
					q = num / len;
					o.res_x = clamp_word(a[0] < 0 ? -$signed(q) : $signed(q), ovf);
					num = (a[1] < 0 ? -a[1] : a[1]) << FRAC_BITS;
					q = num / len;
					o.res_y = clamp_word(a[1] < 0 ? -$signed(q) : $signed(q), ovf);
					num = (a[2] < 0 ? -a[2] : a[2]) << FRAC_BITS;
					q = num / len;
					o.res_z = clamp_word(a[2] < 0 ? -$signed(q) : $signed(q), ovf);
				end
			end
		endcase
		o.overflow = ovf;
		return o;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			expected_q.delete();
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (req_valid && req_ready) begin
				expected_q.push_back(vector_result(req));
			end
			if (rsp_valid && rsp_ready) begin
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result item %h", rsp);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (want !== rsp) begin
						if (fail_count < 10)
							$display("mismatch: expected x=%h y=%h z=%h s=%h zl=%b ov=%b, got x=%h y=%h z=%h s=%h zl=%b ov=%b",
								want.res_x, want.res_y, want.res_z, want.res_scalar,
								want.zero_length, want.overflow,
								rsp.res_x, rsp.res_y, rsp.res_z, rsp.res_scalar,
								rsp.zero_length, rsp.overflow);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== dv/vector3_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps

module vector3_arithmetic_unit_test import vau_pkg::*;;

	localparam int N_RANDOM = 1200;
	localparam int LIMIT = 400000;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	in_item_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	out_item_t rsp;

	int fail_count;
	int pending;
	int results_seen;
	int cycles = 0;
	int items_sent;
	bit quiet_phase;

	vector3_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// scoreboard sits beside the block and watches both channels
	vector3_arithmetic_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// receiver stalls at random, except in the quiet stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= quiet_phase || ($urandom_range(99) >= 15);
		end
	end

	// random operand, biased toward edges and small values
	function automatic word_t pick_word();
		case ($urandom_range(7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return word_t'($urandom_range(131072)) - 32'sd65536;
			4: return word_t'($urandom_range(2097152)) - 32'sd1048576;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.func = 3'($urandom_range(7));
		it.a_x = pick_word(); it.a_y = pick_word(); it.a_z = pick_word();
		it.b_x = pick_word(); it.b_y = pick_word(); it.b_z = pick_word();
		it.scale_factor = pick_word();
		// small vectors, which may be zero, for normalize now and then
		if ($urandom_range(3) == 0) begin
			it.a_x = word_t'($urandom_range(6)) - 32'sd3;
			it.a_y = word_t'($urandom_range(6)) - 32'sd3;
			it.a_z = word_t'($urandom_range(6)) - 32'sd3;
		end
		return it;
	endfunction

	// hold the item until accepted; optional random idle first
	task automatic send_item(input in_item_t it);
		while (!quiet_phase && $urandom_range(99) < 15) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		items_sent++;
	endtask

	function automatic in_item_t make_item(input func_t f, input word_t a, input word_t b,
		input word_t s);
		in_item_t it;
		it.func = f;
		it.a_x = a; it.a_y = a; it.a_z = a;
		it.b_x = b; it.b_y = -b; it.b_z = b;
		it.scale_factor = s;
		return it;
	endfunction

	initial begin
		items_sent = 0;
		quiet_phase = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every operation at the word extremes
		for (int f = 0; f < 8; f++) begin
			send_item(make_item(func_t'(f), 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
			send_item(make_item(func_t'(f), 32'sh80000000, 32'sh7fffffff, 32'sh80000000));
		end
		// zero vector normalize, tiny normalize, zero length, unit scale, rounding ties, negate of the minimum
		send_item(make_item(FN_NORM, '0, '0, '0));
		send_item(make_item(FN_NORM, 32'sd1, '0, '0));
		send_item(make_item(FN_LEN, '0, '0, '0));
		send_item(make_item(FN_SCALE, 32'sh00010000, '0, 32'sh00010000));
		send_item(make_item(FN_SCALE, 32'sd1, '0, 32'sh00008000));
		send_item(make_item(FN_SCALE, -32'sd1, '0, 32'sh00008000));
		send_item(make_item(FN_NEG, 32'sh80000000, '0, '0));

		// let the pipeline drain completely before random traffic
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			quiet_phase = (i >= 400 && i < 600);
			send_item(random_item());
		end
		quiet_phase = 1'b0;
		req_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("sent %0d items over all eight operations, checked %0d results",
			items_sent, results_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAIL");
		end
		$finish;
	end

endmodule
